// File: rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg - civil calendar converter shared definitions
// Constants, reciprocal multipliers, the month offset lookup and the
// pipeline stage record used by the converter datapath.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int unsigned NUM_STAGES  = 12;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 104;

  // Seconds are split as s = (s >> 7) * 128 + s[6:0]; 86400 = 675 * 128.
  localparam logic [9:0]  SEC_UNIT  = 10'd675;
  localparam logic [32:0] SEC_BIAS  = 33'd2831155200;  // 675 * 2^22, keeps dividend positive
  localparam logic [22:0] DAY_BIAS  = 23'd4194304;     // 2^22, removed again from the quotient

  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
  localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
  localparam logic [19:0] EPOCH_SHIFT   = 20'd719468;
  localparam logic [23:0] ERA_BIAS      = 24'd865565;  // epoch shift plus one era
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [8:0]  YEARS_PER_ERA = 9'd400;

  // Day numbers of 0000-01-01 and 9999-12-31.
  localparam logic signed [22:0] DN_MIN = -23'sd719528;
  localparam logic signed [22:0] DN_MAX = 23'sd2932896;

  // Reciprocals. The seconds one is a floor estimate that needs one correction;
  // the rest are rounded up with enough fraction bits to be exact over their range.
  localparam logic [30:0] RCP_675   = 31'((64'd1 << 40) / 64'd675);
  localparam logic [22:0] RCP_ERA   = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
  localparam logic [18:0] RCP_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] RCP_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] RCP_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  RCP_100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] RCP_153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [14:0] RCP_400   = 15'(((64'd1 << 23) + 64'd399) / 64'd400);

  // First day of each shifted month (March = 0), counted in the March-based year.
  function automatic logic [8:0] month_offset(input logic [3:0] mi);
    logic [8:0] off;
    case (mi)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      4'd12:   off = 9'd367;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  typedef struct packed {
    logic               op;
    // seconds-to-date lane
    logic [32:0]        u;
    logic [6:0]         lo7;
    logic [22:0]        qe;
    logic [10:0]        rem;
    logic signed [22:0] q;
    logic [16:0]        sod;
    logic               oor;
    logic [21:0]        z2;
    logic [4:0]         cyc;
    logic [17:0]        dic;
    logic [17:0]        tsum;
    logic [8:0]         yic;
    logic [8:0]         diy;
    logic [3:0]         mi;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    // date-to-day lane
    logic signed [14:0] ys;
    logic [3:0]         bmi;
    logic [4:0]         bday;
    logic signed [6:0]  bcyc;
    logic signed [9:0]  bdiy;
    logic [8:0]         byic;
    logic [17:0]        ba;
    logic [1:0]         bh;
    logic signed [18:0] bdic;
    // merged result
    logic signed [24:0] dn;
    logic [38:0]        dstart;
  } stg_t;

endpackage

// File: rtl/civil_calendar_converter.sv
// ----------------------------------------------------------------------------
// civil_calendar_converter - Unix seconds <-> proleptic Gregorian date
// Twelve-stage pipeline built on 400-year era arithmetic; every division is
// a constant reciprocal multiply, so one conversion enters per cycle while m_axis is taken.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata fields (low bit up)                          tuser
//  s_axis    in   epoch_secs, in_year, in_month, in_day, 2'b0        op
//  m_axis    out  out_year, out_month, out_day, second_of_day,       out_of_range
//                 epoch_day, day_start_seconds, 2'b0
//
//  Stage 0 loads at the input transfer edge and an item moves on into the next
//  stage at each edge on which that stage is enabled, passing stages 0 to 11 in
//  order to m_axis; one transfer per cycle is sustained by the 12-stage chain while m_axis is taken.
//  Reset clears the stage valid bits only; the datapath registers are unreset.
//  A stage advances when any stage at or after it is empty or the output is
//  taken, so bubbles close up and input keeps flowing while a result waits.
//
module civil_calendar_converter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // epoch_secs[38:0], in_year[52:39], in_month[56:53], in_day[61:57], pad
  input  logic [63:0]  s_axis_tdata,
  // op
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_year[13:0], out_month[17:14], out_day[22:18], second_of_day[39:23],
  // epoch_day[62:40], day_start_seconds[101:63], pad
  output logic [103:0] m_axis_tdata,
  // out_of_range
  output logic         m_axis_tuser
);

  localparam int unsigned NumStages = ccc_pkg::NUM_STAGES;

  ccc_pkg::stg_t          stg_q [NumStages];
  ccc_pkg::stg_t          stg_d [NumStages];
  logic [NumStages-1:0]   valid_q;
  logic [NumStages-1:0]   valid_d;
  logic [NumStages-1:0]   stage_en;

  // A stage may load when it or a stage downstream of it is empty, or the output is taken.
  for (genvar k = 0; k < NumStages; k++) begin : g_en
    assign stage_en[k] = m_axis_tready | ~(&valid_q[NumStages-1:k]);
  end

  assign valid_d = {valid_q[NumStages-2:0], s_axis_tvalid};

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (stage_en[k]) begin
        valid_q[k] <= valid_d[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_en[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  always_comb begin
    logic [33:0] u_sum;
    logic [63:0] p_sec;
    logic [28:0] p_y400;
    logic [33:0] r_sum;
    logic [14:0] yb;
    logic [22:0] qn;
    logic [10:0] rn;
    logic [18:0] p_b100;
    logic [23:0] z2w;
    logic [44:0] p_era;
    logic [22:0] dw;
    logic [36:0] p1460;
    logic [36:0] p36524;
    logic [36:0] p365;
    logic [18:0] p100;
    logic [17:0] yd;
    logic [17:0] dd;
    logic [10:0] x153;
    logic [22:0] p153;
    logic [8:0]  dayw;
    logic [14:0] yw;

    // Stage 0: capture, bias the seconds quotient positive, shift the year.
    stg_d[0]      = '0;
    stg_d[0].op   = s_axis_tuser;
    u_sum         = 34'(signed'(s_axis_tdata[38:7])) + 34'(ccc_pkg::SEC_BIAS);
    stg_d[0].u    = u_sum[32:0];
    stg_d[0].lo7  = s_axis_tdata[6:0];
    stg_d[0].ys   = signed'(15'({1'b0, s_axis_tdata[52:39]})
                    - 15'(s_axis_tdata[56:53] <= 4'd2));
    stg_d[0].bmi  = (s_axis_tdata[56:53] > 4'd2) ? 4'(s_axis_tdata[56:53] - 4'd3)
                                                 : 4'(s_axis_tdata[56:53] + 4'd9);
    stg_d[0].bday = s_axis_tdata[61:57];

    // Stage 1: quotient estimate by 675; era of the civil year; day in year.
    stg_d[1]      = stg_q[0];
    p_sec         = 64'(stg_q[0].u) * 64'(ccc_pkg::RCP_675);
    stg_d[1].qe   = p_sec[62:40];
    p_y400        = 29'(stg_q[0].ys[13:0]) * 29'(ccc_pkg::RCP_400);
    stg_d[1].bcyc = stg_q[0].ys[14] ? -7'sd1 : signed'(7'(p_y400[28:23]));
    stg_d[1].bdiy = signed'(10'(ccc_pkg::month_offset(stg_q[0].bmi))
                    + 10'(stg_q[0].bday) - 10'd1);

    // Stage 2: remainder of the estimate; year of era.
    stg_d[2]      = stg_q[1];
    r_sum         = 34'(stg_q[1].u) - 34'(stg_q[1].qe) * 34'(ccc_pkg::SEC_UNIT);
    stg_d[2].rem  = r_sum[10:0];
    yb            = 15'(stg_q[1].ys) - 15'(stg_q[1].bcyc) * 15'(ccc_pkg::YEARS_PER_ERA);
    stg_d[2].byic = yb[8:0];

    // Stage 3: correct the quotient by one, range check; year-of-era days.
    stg_d[3] = stg_q[2];
    qn       = stg_q[2].qe;
    rn       = stg_q[2].rem;
    if (stg_q[2].rem >= 11'(ccc_pkg::SEC_UNIT)) begin
      qn = 23'(stg_q[2].qe + 23'd1);
      rn = 11'(stg_q[2].rem - 11'(ccc_pkg::SEC_UNIT));
    end
    stg_d[3].q    = signed'(23'(qn - ccc_pkg::DAY_BIAS));
    stg_d[3].sod  = {rn[9:0], stg_q[2].lo7};
    stg_d[3].oor  = (signed'(23'(qn - ccc_pkg::DAY_BIAS)) < ccc_pkg::DN_MIN)
                 || (signed'(23'(qn - ccc_pkg::DAY_BIAS)) > ccc_pkg::DN_MAX);
    stg_d[3].ba   = 18'(stg_q[2].byic) * 18'(ccc_pkg::DAYS_PER_YEAR)
                  + 18'(stg_q[2].byic[8:2]);
    p_b100        = 19'(stg_q[2].byic) * 19'(ccc_pkg::RCP_100);
    stg_d[3].bh   = p_b100[17:16];

    // Stage 4: shifted day count and its era; day of era on the date side.
    stg_d[4]      = stg_q[3];
    z2w           = 24'(stg_q[3].q) + ccc_pkg::ERA_BIAS;
    stg_d[4].z2   = z2w[21:0];
    p_era         = 45'(z2w[21:0]) * 45'(ccc_pkg::RCP_ERA);
    stg_d[4].cyc  = p_era[44:40];
    stg_d[4].bdic = signed'(19'(stg_q[3].ba) - 19'(stg_q[3].bh) + 19'(stg_q[3].bdiy));

    // Stage 5: day of era; day number on the date side.
    stg_d[5]     = stg_q[4];
    dw           = 23'(stg_q[4].z2) - 23'(stg_q[4].cyc) * 23'(ccc_pkg::DAYS_PER_ERA);
    stg_d[5].dic = dw[17:0];
    stg_d[5].dn  = signed'(25'(stg_q[4].bcyc) * 25'(ccc_pkg::DAYS_PER_ERA)
                   + 25'(stg_q[4].bdic) - 25'(ccc_pkg::EPOCH_SHIFT));

    // Stage 6: strip leap days out of the day of era.
    stg_d[6]      = stg_q[5];
    p1460         = 37'(stg_q[5].dic) * 37'(ccc_pkg::RCP_1460);
    p36524        = 37'(stg_q[5].dic) * 37'(ccc_pkg::RCP_36524);
    stg_d[6].tsum = stg_q[5].dic - 18'(p1460[36:29]) + 18'(p36524[36:34])
                  - 18'(stg_q[5].dic == ccc_pkg::ERA_LAST_DAY);

    // Stage 7: year of era.
    stg_d[7]     = stg_q[6];
    p365         = 37'(stg_q[6].tsum) * 37'(ccc_pkg::RCP_365);
    stg_d[7].yic = p365[35:27];

    // Stage 8: day of the March-based year.
    stg_d[8]     = stg_q[7];
    p100         = 19'(stg_q[7].yic) * 19'(ccc_pkg::RCP_100);
    yd           = 18'(stg_q[7].yic) * 18'(ccc_pkg::DAYS_PER_YEAR)
                 + 18'(stg_q[7].yic[8:2]) - 18'(p100[17:16]);
    dd           = stg_q[7].dic - yd;
    stg_d[8].diy = dd[8:0];

    // Stage 9: shifted month index.
    stg_d[9]    = stg_q[8];
    x153        = 11'(stg_q[8].diy) * 11'd5 + 11'd2;
    p153        = 23'(x153) * 23'(ccc_pkg::RCP_153);
    stg_d[9].mi = p153[22:19];

    // Stage 10: civil year, month, day; pick the day number for either op.
    // cyc runs one era ahead, so take one era back off (wraps through year 0).
    stg_d[10]       = stg_q[9];
    stg_d[10].month = (stg_q[9].mi < 4'd10) ? 4'(stg_q[9].mi + 4'd3)
                                             : 4'(stg_q[9].mi - 4'd9);
    dayw            = stg_q[9].diy - ccc_pkg::month_offset(stg_q[9].mi) + 9'd1;
    stg_d[10].day   = dayw[4:0];
    yw              = 15'(stg_q[9].yic)
                    + 15'(stg_q[9].cyc) * 15'(ccc_pkg::YEARS_PER_ERA)
                    - 15'(ccc_pkg::YEARS_PER_ERA)
                    + 15'(stg_q[9].mi >= 4'd10);
    stg_d[10].year  = yw[13:0];
    if (!stg_q[9].op) begin
      stg_d[10].dn = 25'(stg_q[9].q);
    end

    // Stage 11: midnight seconds; zero the fields that do not apply.
    stg_d[11]        = stg_q[10];
    stg_d[11].dstart = 39'(stg_q[10].dn) * 39'(ccc_pkg::SEC_PER_DAY);
    if (stg_q[10].op) begin
      stg_d[11].year  = '0;
      stg_d[11].month = '0;
      stg_d[11].day   = '0;
      stg_d[11].sod   = '0;
      stg_d[11].oor   = 1'b0;
    end else if (stg_q[10].oor) begin
      stg_d[11].year   = '0;
      stg_d[11].month  = '0;
      stg_d[11].day    = '0;
      stg_d[11].sod    = '0;
      stg_d[11].dn     = '0;
      stg_d[11].dstart = '0;
    end
  end

  // Drive the result straight from the last stage register.
  assign s_axis_tready = stage_en[0];
  assign m_axis_tvalid = valid_q[NumStages-1];
  assign m_axis_tuser  = stg_q[NumStages-1].oor;
  assign m_axis_tdata  = {2'b00,
                          stg_q[NumStages-1].dstart,
                          stg_q[NumStages-1].dn[22:0],
                          stg_q[NumStages-1].sod,
                          stg_q[NumStages-1].day,
                          stg_q[NumStages-1].month,
                          stg_q[NumStages-1].year};

endmodule
